/* src/tlc_pkg.sv */
// Shared types and constants for the timestamp LRU tag cache.
package tlc_pkg;

    // Width of the slot field on the result channel.
    localparam int unsigned SLOT_W = 6;

    // Tag value reserved as the empty marker.
    localparam logic [31:0] EMPTY_TAG = 32'hFFFF_FFFF;

    // Input action codes.
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INVAL  = 1'b1;

    // One stored entry of the tag store.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] stamp;
    } entry_t;

    // Write request from the sequencer to the tag store.
    typedef struct packed {
        logic   wr_en;
        entry_t wr_data;
    } store_req_t;

endpackage

/* src/tlc_store.sv */
// Single-port-write, single-port-read entry store with registered read data.
module tlc_store
    import tlc_pkg::*;
#(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
    input  logic             aclk,
    input  store_req_t       req,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Write one entry per cycle; read one entry per cycle into a register.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/timestamp_lru_tag_cache_top.sv */
// Top level of the fully associative tag cache with timestamp LRU replacement.
//
// The cache holds ENTRIES entries of a valid mark, a 32-bit tag and a 32-bit
// last-use time in a single memory with one read and one write port. A lookup
// streams every entry through one shared tag and time comparator, one entry
// per cycle, stopping early on the first matching valid entry. An invalidate
// clears the entries with a sweep through the write port before its result is
// offered. After reset the same clearing sweep runs, and no transaction is
// accepted until it completes. One transaction is worked on at a time; a
// finished result sits in an output register, so a new transaction can be
// accepted while the previous result waits to be taken.
module timestamp_lru_tag_cache_top
    import tlc_pkg::*;
#(
    parameter int unsigned ENTRIES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [31:0]       s_tag,
    input  logic [31:0]       s_now_time,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_filled,
    output logic              m_evicted
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             pend_reg;
    logic             last_reg;
    logic             inval_reg;
    logic             hit_reg;
    logic             free_found_reg;
    logic             old_found_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] old_idx_reg;
    logic [31:0]      old_time_reg;
    logic [31:0]      tag_reg;
    logic [31:0]      time_reg;

    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_filled_reg;
    logic              m_evicted_reg;

    store_req_t       st_req;
    logic [IDX_W-1:0] wr_addr;
    entry_t           rd_data;
    logic [IDX_W-1:0] chosen;
    logic             ent_free;
    logic             ent_match;
    logic             ent_older;
    logic             s_acc;
    logic             out_free;

    tlc_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .req     (st_req),
        .wr_addr (wr_addr),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Shared comparator: classifies the entry read in the previous cycle.
    assign ent_free  = pend_reg && !rd_data.valid;
    assign ent_match = pend_reg && rd_data.valid && (rd_data.tag == tag_reg)
                       && (tag_reg != EMPTY_TAG);
    assign ent_older = pend_reg && rd_data.valid && !ent_match
                       && (!old_found_reg || (rd_data.stamp < old_time_reg));

    // Slot written at the end of a lookup: the hit, else the last free, else the oldest.
    always_comb begin
        priority if (hit_reg) begin
            chosen = hit_idx_reg;
        end else if (free_found_reg) begin
            chosen = free_idx_reg;
        end else begin
            chosen = old_idx_reg;
        end
    end

    // Store write port: clearing sweep or the final update of a lookup.
    always_comb begin
        st_req.wr_en         = 1'b0;
        st_req.wr_data.valid = tag_reg != EMPTY_TAG;
        st_req.wr_data.tag   = tag_reg;
        st_req.wr_data.stamp = time_reg;
        wr_addr              = addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                st_req.wr_en         = 1'b1;
                st_req.wr_data.valid = 1'b0;
            end
            ST_WRITE: begin
                st_req.wr_en = 1'b1;
                wr_addr      = chosen;
            end
            default: begin
                st_req.wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer: state, scan flags and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            last_reg       <= 1'b0;
            inval_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // A taken result is dropped unless a new one replaces it in this cycle.
            if (m_valid_reg && m_ready && !((state_reg == ST_DONE) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (addr_reg == LAST_IDX) begin
                        addr_reg  <= '0;
                        state_reg <= inval_reg ? ST_DONE : ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        addr_reg       <= '0;
                        pend_reg       <= 1'b0;
                        last_reg       <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        old_found_reg  <= 1'b0;
                        inval_reg      <= (s_action == ACT_INVAL);
                        state_reg      <= (s_action == ACT_INVAL) ? ST_CLEAR : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Issue the next read while the previous entry is judged.
                    pend_reg <= !last_reg;
                    if (addr_reg == LAST_IDX) begin
                        last_reg <= 1'b1;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    if (ent_free) begin
                        free_found_reg <= 1'b1;
                    end
                    if (ent_older) begin
                        old_found_reg <= 1'b1;
                    end
                    if (ent_match) begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_WRITE;
                    end else if (pend_reg && (idx_reg == LAST_IDX)) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Data path registers: input payload, scan indices and result fields.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tag_reg     <= s_tag;
            time_reg    <= s_now_time;
            old_idx_reg <= '0;
        end
        if (state_reg == ST_SCAN) begin
            idx_reg <= addr_reg;
            if (ent_free) begin
                free_idx_reg <= idx_reg;
            end
            if (ent_match) begin
                hit_idx_reg <= idx_reg;
            end
            if (ent_older) begin
                old_idx_reg  <= idx_reg;
                old_time_reg <= rd_data.stamp;
            end
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_hit_reg     <= !inval_reg && hit_reg;
            m_slot_reg    <= inval_reg ? '0 : SLOT_W'(chosen);
            m_filled_reg  <= !inval_reg && !hit_reg;
            m_evicted_reg <= !inval_reg && !hit_reg && !free_found_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_slot    = m_slot_reg;
    assign m_filled  = m_filled_reg;
    assign m_evicted = m_evicted_reg;

    // A new result is only raised from the result hand-off state.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result raised outside the hand-off state");

    // The store is never written while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !st_req.wr_en)
        else $error("Store written during a scan");

    // A hit never reports a fill or an eviction.
    a_hit_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (!m_filled && !m_evicted))
        else $error("Hit reported together with a fill");

    // An eviction is always part of a fill.
    a_evict_is_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> m_filled)
        else $error("Eviction reported without a fill");

endmodule

/* bench/timestamp_lru_tag_cache_top_test.sv */
// Self-checking testbench for the timestamp LRU tag cache top level.
module timestamp_lru_tag_cache_top_test;
    import tlc_pkg::*;

    localparam int unsigned CACHE_ENTRIES = 64;
    localparam int unsigned POOL_SIZE     = 96;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned PHASE_ITEMS   = 216;

    // One lookup outcome as it appears on the result channel.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              filled;
        logic              evicted;
    } outcome_t;

    // Mirror of the cache contents plus the queue of outcomes still owed by the block.
    class tag_cache_scoreboard;
        logic        line_valid [CACHE_ENTRIES];
        logic [31:0] line_tag   [CACHE_ENTRIES];
        logic [31:0] line_stamp [CACHE_ENTRIES];
        outcome_t    expected_outcomes [$];
        int unsigned failures;
        int unsigned n_hits;
        int unsigned n_fills;
        int unsigned n_evicts;
        int unsigned n_invals;

        function new();
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
        endfunction

        function int unsigned pending();
            return expected_outcomes.size();
        endfunction

        // Work out the outcome of an accepted transaction and update the mirror.
        function void note_request(logic action, logic [31:0] tag, logic [31:0] now_time);
            outcome_t res;
            int       free_idx;
            int       oldest_idx;
            int       pick;
            bit       found;
            res        = '0;
            free_idx   = -1;
            oldest_idx = -1;
            found      = 1'b0;
            if (action == ACT_INVAL) begin
                for (int i = 0; i < CACHE_ENTRIES; i++)
                    line_valid[i] = 1'b0;
                n_invals++;
            end else begin
                // Scan in index order: first matching valid entry wins.
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (!line_valid[i]) begin
                        free_idx = i;
                    end else begin
                        if (line_tag[i] == tag && tag != EMPTY_TAG) begin
                            line_stamp[i] = now_time;
                            res.hit       = 1'b1;
                            res.slot      = i[SLOT_W-1:0];
                            found         = 1'b1;
                            break;
                        end
                        if (oldest_idx < 0 || line_stamp[i] < line_stamp[oldest_idx])
                            oldest_idx = i;
                    end
                end
                if (found) begin
                    n_hits++;
                end else begin
                    // Miss: highest free entry, otherwise the least recently used one.
                    if (free_idx >= 0) begin
                        pick = free_idx;
                    end else begin
                        pick        = (oldest_idx >= 0) ? oldest_idx : 0;
                        res.evicted = 1'b1;
                        n_evicts++;
                    end
                    line_tag[pick]   = tag;
                    line_stamp[pick] = now_time;
                    line_valid[pick] = (tag != EMPTY_TAG);
                    res.slot         = pick[SLOT_W-1:0];
                    res.filled       = 1'b1;
                    n_fills++;
                end
            end
            expected_outcomes.push_back(res);
        endfunction

        // Compare a result transaction with the oldest outstanding outcome.
        function void check_result(logic hit, logic [SLOT_W-1:0] slot, logic filled,
                                   logic evicted);
            outcome_t want;
            if (expected_outcomes.size() == 0) begin
                $error("result with no outstanding transaction: hit %0d slot %0d",
                       hit, slot);
                failures++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (hit !== want.hit) begin
                $error("hit mismatch: expected %0d, got %0d", want.hit, hit);
                failures++;
            end
            if (slot !== want.slot) begin
                $error("slot mismatch: expected %0d, got %0d", want.slot, slot);
                failures++;
            end
            if (filled !== want.filled) begin
                $error("filled mismatch: expected %0d, got %0d", want.filled, filled);
                failures++;
            end
            if (evicted !== want.evicted) begin
                $error("evicted mismatch: expected %0d, got %0d", want.evicted, evicted);
                failures++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic [31:0]       s_tag;
    logic [31:0]       s_now_time;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic [SLOT_W-1:0] m_slot;
    logic              m_filled;
    logic              m_evicted;

    tag_cache_scoreboard board;
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    bit                  hold_off_req   = 1'b0;
    int unsigned         cycle_count    = 0;
    logic [31:0]         tag_pool [POOL_SIZE];
    logic [31:0]         now_ctr;

    timestamp_lru_tag_cache_top #(
        .ENTRIES(CACHE_ENTRIES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_tag     (s_tag),
        .s_now_time(s_now_time),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .m_slot    (m_slot),
        .m_filled  (m_filled),
        .m_evicted (m_evicted)
    );

    // Scoreboard created at time zero.
    initial begin
        board = new();
    end

    always #10 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result transaction is checked at the clock edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_hit, m_slot, m_filled, m_evicted);
    end

    // Offer one transaction, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_item(input logic action, input logic [31:0] tag,
                             input logic [31:0] stamp);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_action   = action;
        s_tag      = tag;
        s_now_time = stamp;
        do @(posedge aclk); while (!s_ready);
        board.note_request(action, tag, stamp);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Random transaction: mostly pooled tags so that hits and evictions both occur.
    task automatic send_random(input int unsigned span);
        int unsigned roll;
        logic        action;
        logic [31:0] tag;
        logic [31:0] stamp;
        roll   = $urandom_range(999);
        action = ACT_LOOKUP;
        tag    = $urandom;
        if (roll < 8) begin
            action = ACT_INVAL;
        end else if (roll < 20) begin
            tag = EMPTY_TAG;
        end else if (roll < 200) begin
            if (tag == EMPTY_TAG)
                tag = '0;
        end else begin
            tag = tag_pool[$urandom_range(span - 1)];
        end
        // Mostly a slowly rising clock, so ties on the oldest time are common.
        if ($urandom_range(19) == 0) begin
            stamp = $urandom;
        end else begin
            now_ctr = now_ctr + $urandom_range(3);
            stamp   = now_ctr;
        end
        send_item(action, tag, stamp);
    endtask

    // Main sequence: reset, directed transactions, then randomised phases.
    initial begin
        int unsigned span;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_action   = ACT_LOOKUP;
        s_tag      = '0;
        s_now_time = '0;
        #1;
        tag_pool[0] = '0;
        tag_pool[1] = 32'hFFFF_FFFE;
        for (int i = 2; i < POOL_SIZE; i++) begin
            tag_pool[i] = $urandom;
            if (tag_pool[i] == EMPTY_TAG)
                tag_pool[i] = 32'h0000_FFFF;
        end
        now_ctr = $urandom;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, hit after fill, empty-marker tag, invalidation.
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFE, 32'h8000_0000);
        send_item(ACT_LOOKUP, EMPTY_TAG, 32'h0000_0005);
        send_item(ACT_LOOKUP, EMPTY_TAG, 32'h0000_0006);
        send_item(ACT_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0001);
        send_item(ACT_LOOKUP, 32'h5555_5555, 32'h0000_0001);
        send_item(ACT_LOOKUP, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
        send_item(ACT_INVAL, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0002);
        send_item(ACT_INVAL, EMPTY_TAG, 32'hFFFF_FFFF);
        send_item(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0002);
        drain_results();

        // Random phases under each idling pattern, twice over.
        for (int round = 0; round < 2; round++) begin
            for (int ph = 0; ph < 4; ph++) begin
                case (ph)
                    0: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    1: begin
                        send_idle_pct  = 53;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 53;
                    end
                    default: begin
                        send_idle_pct  = 7;
                        recv_stall_pct = 7;
                    end
                endcase
                span = $urandom_range(40, POOL_SIZE);
                for (int n = 0; n < PHASE_ITEMS; n++) begin
                    // Back the block up once with a long stall on the result side.
                    if (round == 0 && ph == 0 && n == 60)
                        hold_off_req = 1'b1;
                    send_random(span);
                end
                drain_results();
            end
        end

        // Allow for any stray result after the last expected one.
        repeat (CACHE_ENTRIES + 16) @(posedge aclk);
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.failures++;
        end

        $display("Run covered %0d hits and %0d fills (%0d evicting) plus %0d invalidations,",
                 board.n_hits, board.n_fills, board.n_evicts, board.n_invals);
        $display("under free-running, sender-idle, receiver-stall and mixed handshake timing.");
        if (board.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* timestamp_lru_tag_cache_top.f */
src/tlc_pkg.sv
src/tlc_store.sv
src/timestamp_lru_tag_cache_top.sv
bench/timestamp_lru_tag_cache_top_test.sv
